/* design/sird_pkg.sv */
package sird_pkg;

    // Fixed widths of the data path.
    localparam int VALUE_W    = 32;
    localparam int RADIX_W    = 5;
    localparam int ALPHA_W    = 64;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int MAX_RADIX  = 16;
    localparam int MAX_DIGITS = 32;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int STK_AW     = $clog2(MAX_DIGITS);

    // The divider retires this many quotient bits per cycle.
    localparam int DIV_STEP   = 8;
    localparam int DIV_CYC    = VALUE_W / DIV_STEP;
    localparam int DIV_CW     = $clog2(DIV_CYC);

    // Configuration register indexes.
    localparam int CFG_AW     = 2;
    localparam logic [CFG_AW-1:0] REG_RADIX      = 2'd0;
    localparam logic [CFG_AW-1:0] REG_ALPHA_LOW  = 2'd1;
    localparam logic [CFG_AW-1:0] REG_ALPHA_HIGH = 2'd2;

    // Reset contents of the configuration registers: base ten, "0123456789".
    localparam logic [RADIX_W-1:0] RADIX_RST      = 5'd10;
    localparam logic [ALPHA_W-1:0] ALPHA_LOW_RST  = 64'h3736_3534_3332_3130;
    localparam logic [ALPHA_W-1:0] ALPHA_HIGH_RST = 64'h0000_0000_0000_3938;

    localparam logic [CHAR_W-1:0] CODE_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CODE_MINUS = 8'h2D;

    typedef struct packed {
        logic                start;
        logic [VALUE_W-1:0]  dividend;
        logic [RADIX_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [VALUE_W-1:0]  quotient;
        logic [DIGIT_W-1:0]  remainder;
    } div_rsp_t;

    // Character code of digit d from the two alphabet words.
    function automatic logic [CHAR_W-1:0] alphabet_code(
        input logic [DIGIT_W-1:0] d,
        input logic [ALPHA_W-1:0] lo,
        input logic [ALPHA_W-1:0] hi
    );
        logic [ALPHA_W-1:0] word;
        word = d[3] ? hi : lo;
        return word[{d[2:0], 3'b000} +: CHAR_W];
    endfunction

endpackage

/* design/sird_div.sv */
module sird_div
    import sird_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DIV_CW-1:0]   cnt_reg, cnt_next;
    logic [VALUE_W-1:0]  work_reg, work_next;
    logic [DIGIT_W-1:0]  rem_reg, rem_next;
    logic [DIV_STEP-1:0] qbyte;
    logic [DIGIT_W-1:0]  rem_step;

    // Restoring division of the top byte of the work word by the radix.
    // The remainder stays below the radix, so it fits in a digit.
    always_comb begin
        logic [DIGIT_W:0]   t;
        logic [DIGIT_W-1:0] r;
        r     = rem_reg;
        qbyte = '0;
        for (int b = 0; b < DIV_STEP; b++) begin
            t = {r, work_reg[VALUE_W-1-b]};
            if (t >= req.divisor) begin
                qbyte[DIV_STEP-1-b] = 1'b1;
                t = t - req.divisor;
            end
            r = t[DIGIT_W-1:0];
        end
        rem_step = r;
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        if (busy_reg) begin
            // Quotient bits shift in from the bottom as dividend bits leave the top.
            work_next = {work_reg[VALUE_W-DIV_STEP-1:0], qbyte};
            rem_next  = rem_step;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CW'(DIV_CYC - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req.start) begin
            busy_next = 1'b1;
            work_next = req.dividend;
            rem_next  = '0;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = work_reg;
    assign rsp.remainder = rem_reg;

endmodule

/* design/signed_integer_to_radix_digits.sv */
// Signed integer to radix digits.
// Each beat on the s_ channel carries one signed 32-bit value. The block
// answers with its digits in the configured radix on the m_ channel, one
// character code per beat, most significant digit first, preceded by a minus
// sign for a negative value. m_tlast marks the final character of a number.
// If the alphabet is invalid (radix below two or above sixteen, a plus or
// minus sign among the codes in use, or a code repeated among them), the
// value is consumed and no beat is produced.
// The user must write the radix and alphabet through the cfg_ port only
// while the block is idle; the block itself does not enforce it. A new value
// is taken only when the previous one is fully converted; the last character
// may still sit in the output register then. Each value first passes the
// alphabet check, then goes through the divider once per digit, each
// remainder being stored as a digit, and the characters then leave one per
// cycle while the receiver takes every beat.
// When m_tready is low the output register holds its beat and the emitter
// waits. Reset returns to base ten with the digits "0123456789" and empties
// the output register.
module signed_integer_to_radix_digits
    import sird_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    // Configuration writes.
    input  logic                cfg_wr_en,
    input  logic [CFG_AW-1:0]   cfg_index,
    input  logic [ALPHA_W-1:0]  cfg_wdata,

    // Input stream.
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [VALUE_W-1:0]  s_tdata,    // [31:0] value

    // Result stream.
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [CHAR_W-1:0]   m_tdata,    // [7:0] char_code
    output logic                m_tlast
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    // Configuration registers.
    logic [RADIX_W-1:0] radix_reg;
    logic [ALPHA_W-1:0] alpha_lo_reg;
    logic [ALPHA_W-1:0] alpha_hi_reg;

    // Alphabet check, registered once per cycle from the configuration.
    logic alpha_ok;
    logic alpha_ok_reg;

    // Sequencer state.
    logic [2:0]          state_reg, state_next;
    logic [VALUE_W-1:0]  mag_reg, mag_next;
    logic                neg_reg, neg_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    // Digits are gathered least significant first and read back in reverse.
    // The read register fetches the digit of the next character in advance,
    // indexed by the next count; a digit written in the same cycle is passed straight through.
    logic [DIGIT_W-1:0]  stack_mem [MAX_DIGITS];
    logic                stack_we;
    logic [STK_AW-1:0]   rd_idx;
    logic [DIGIT_W-1:0]  rd_digit_reg;

    // Output register.
    logic                m_tvalid_reg;
    logic [CHAR_W-1:0]   m_tdata_reg;
    logic                m_tlast_reg;
    logic                out_free;
    logic                out_load;
    logic [CHAR_W-1:0]   out_char;
    logic                out_last;

    div_req_t div_req;
    div_rsp_t div_rsp;

    sird_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg    <= RADIX_RST;
            alpha_lo_reg <= ALPHA_LOW_RST;
            alpha_hi_reg <= ALPHA_HIGH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_RADIX:      radix_reg    <= cfg_wdata[RADIX_W-1:0];
                REG_ALPHA_LOW:  alpha_lo_reg <= cfg_wdata;
                REG_ALPHA_HIGH: alpha_hi_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Every code in use is compared with every later one; codes past the
    // radix take no part.
    always_comb begin
        logic [CHAR_W-1:0] ci;
        alpha_ok = (radix_reg >= RADIX_W'(2)) && (radix_reg <= RADIX_W'(MAX_RADIX));
        for (int i = 0; i < MAX_RADIX; i++) begin
            ci = alphabet_code(DIGIT_W'(i), alpha_lo_reg, alpha_hi_reg);
            if (RADIX_W'(i) < radix_reg) begin
                if (ci == CODE_PLUS || ci == CODE_MINUS) begin
                    alpha_ok = 1'b0;
                end
                for (int j = i + 1; j < MAX_RADIX; j++) begin
                    if (RADIX_W'(j) < radix_reg &&
                        ci == alphabet_code(DIGIT_W'(j), alpha_lo_reg, alpha_hi_reg)) begin
                        alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_ok_reg <= 1'b0;
        end else begin
            alpha_ok_reg <= alpha_ok;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign rd_idx   = STK_AW'(cnt_next - 1'b1);

    always_comb begin
        state_next       = state_reg;
        mag_next         = mag_reg;
        neg_next         = neg_reg;
        cnt_next         = cnt_reg;
        stack_we         = 1'b0;
        out_load         = 1'b0;
        out_char         = alphabet_code(rd_digit_reg, alpha_lo_reg, alpha_hi_reg);
        out_last         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = mag_reg;
        div_req.divisor  = radix_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    // The magnitude is taken unsigned, so the most negative
                    // value negates to itself and converts correctly.
                    neg_next   = s_tdata[VALUE_W-1];
                    mag_next   = s_tdata[VALUE_W-1] ? (~s_tdata + 1'b1) : s_tdata;
                    cnt_next   = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (alpha_ok_reg) begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    stack_we = (cnt_reg < CNT_W'(MAX_DIGITS));
                    if (stack_we) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    mag_next = div_rsp.quotient;
                    if (div_rsp.quotient != '0) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = div_rsp.quotient;
                    end else begin
                        state_next = neg_reg ? ST_SIGN : ST_EMIT;
                    end
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_char   = CODE_MINUS;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_last = (cnt_reg == CNT_W'(1));
                    cnt_next = cnt_reg - 1'b1;
                    if (out_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            mag_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mag_reg   <= mag_next;
        end
        neg_reg <= neg_next;
    end

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[cnt_reg[STK_AW-1:0]] <= div_rsp.remainder;
        end
        if (stack_we && cnt_reg[STK_AW-1:0] == rd_idx) begin
            rd_digit_reg <= div_rsp.remainder;
        end else begin
            rd_digit_reg <= stack_mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (out_load) begin
            m_tdata_reg <= out_char;
            m_tlast_reg <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTH
    // An accepted value always moves on to the alphabet check.
    a_accept_to_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_CHECK))
        else $error("accepted value did not enter the alphabet check");

    // The divider only reports a result while the sequencer waits for one.
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the division phase");

    // Emission always has at least one digit left and never more than fit.
    a_emit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SIGN || state_reg == ST_EMIT) |->
            (cnt_reg != '0 && cnt_reg <= CNT_W'(MAX_DIGITS)))
        else $error("digit count out of range during emission");

    // Loading the final character ends the number.
    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_last) |=> (state_reg == ST_IDLE && m_tvalid && m_tlast))
        else $error("final character did not close the number");
`endif

endmodule
